@@ hw/rtl/lsft_pkg.sv @@
package lsft_pkg;

   localparam int unsigned CfgWidth   = 16;
   localparam int unsigned CfgIdxW    = 3;
   localparam int unsigned SampleW    = 16;
   localparam int unsigned TimerW     = 32;

   localparam logic [CfgWidth-1:0] LightThresholdRst    = 16'd40000;
   localparam logic [CfgWidth-1:0] FeedbackThresholdRst = 16'd20000;
   localparam logic [CfgWidth-1:0] ReportPeriodRst      = 16'd10000;
   localparam logic [CfgWidth-1:0] SamplePeriodRst      = 16'd500;
   localparam logic [CfgWidth-1:0] FaultHoldRst         = 16'd5000;
   localparam logic [CfgWidth-1:0] ReplyTimeoutRst      = 16'd1000;

   typedef enum logic [CfgIdxW-1:0] {
      REG_LIGHT_THRESHOLD    = 3'd0,
      REG_FEEDBACK_THRESHOLD = 3'd1,
      REG_REPORT_PERIOD      = 3'd2,
      REG_SAMPLE_PERIOD      = 3'd3,
      REG_FAULT_HOLD         = 3'd4,
      REG_REPLY_TIMEOUT      = 3'd5
   } reg_index_type;

   typedef enum logic [1:0] {
      ACT_LIGHT    = 2'd0,
      ACT_FEEDBACK = 2'd1,
      ACT_MODE     = 2'd2,
      ACT_LINK     = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      CMD_MANUAL_OFF  = 2'd0,
      CMD_MANUAL_ON   = 2'd1,
      CMD_AUTO        = 2'd2,
      CMD_MANUAL_KEEP = 2'd3
   } command_type;

   typedef enum logic [1:0] {
      LINK_ARM     = 2'd0,
      LINK_LOST    = 2'd1,
      LINK_DONE    = 2'd2,
      LINK_STARTED = 2'd3
   } link_type;

   typedef enum logic [1:0] {
      COND_OFF   = 2'd0,
      COND_ON    = 2'd1,
      COND_FAULT = 2'd2
   } cond_type;

   typedef struct packed {
      logic [CfgWidth-1:0] light_threshold;
      logic [CfgWidth-1:0] feedback_threshold;
      logic [CfgWidth-1:0] report_period;
      logic [CfgWidth-1:0] sample_period;
      logic [CfgWidth-1:0] fault_hold;
      logic [CfgWidth-1:0] reply_timeout;
   } cfg_type;

   typedef struct packed {
      action_type          action;
      logic [SampleW-1:0]  sample;
      command_type         command;
      link_type            link_event;
   } item_type;

   typedef struct packed {
      logic     lamp_on;
      cond_type lamp_state;
      logic     auto_mode;
      logic     start_report;
      logic     reply_timed_out;
   } result_type;

   // saturating timer advance by one tick
   function automatic logic [TimerW-1:0] sat_add(input logic [TimerW-1:0] a,
                                                 input logic [CfgWidth-1:0] b);
      logic [TimerW:0] sum;
      sum = {1'b0, a} + {{(TimerW+1-CfgWidth){1'b0}}, b};
      return sum[TimerW] ? {TimerW{1'b1}} : sum[TimerW-1:0];
   endfunction

endpackage

@@ hw/rtl/lsft_csr.sv @@
module lsft_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [lsft_pkg::CfgIdxW-1:0]      csr_index,
   input  logic [lsft_pkg::CfgWidth-1:0]     csr_wdata,
   output lsft_pkg::cfg_type                 cfg
);

   lsft_pkg::cfg_type cfg_ff;
   lsft_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (lsft_pkg::reg_index_type'(csr_index))
            lsft_pkg::REG_LIGHT_THRESHOLD:    cfg_in.light_threshold    = csr_wdata;
            lsft_pkg::REG_FEEDBACK_THRESHOLD: cfg_in.feedback_threshold = csr_wdata;
            lsft_pkg::REG_REPORT_PERIOD:      cfg_in.report_period      = csr_wdata;
            lsft_pkg::REG_SAMPLE_PERIOD:      cfg_in.sample_period      = csr_wdata;
            lsft_pkg::REG_FAULT_HOLD:         cfg_in.fault_hold         = csr_wdata;
            lsft_pkg::REG_REPLY_TIMEOUT:      cfg_in.reply_timeout      = csr_wdata;
            default:                          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.light_threshold    <= lsft_pkg::LightThresholdRst;
         cfg_ff.feedback_threshold <= lsft_pkg::FeedbackThresholdRst;
         cfg_ff.report_period      <= lsft_pkg::ReportPeriodRst;
         cfg_ff.sample_period      <= lsft_pkg::SamplePeriodRst;
         cfg_ff.fault_hold         <= lsft_pkg::FaultHoldRst;
         cfg_ff.reply_timeout      <= lsft_pkg::ReplyTimeoutRst;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ hw/rtl/lsft_core.sv @@
module lsft_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  lsft_pkg::item_type   item,
   input  lsft_pkg::cfg_type    cfg,
   output lsft_pkg::result_type result
);

   logic                              relay_ff, relay_in;
   lsft_pkg::cond_type                cond_ff, cond_in;
   logic                              follow_ff, follow_in;
   logic                              armed_ff, armed_in;
   logic                              pending_ff, pending_in;
   logic [lsft_pkg::TimerW-1:0]       report_ff, report_in;
   logic [lsft_pkg::TimerW-1:0]       wait_ff, wait_in;
   logic [lsft_pkg::TimerW-1:0]       fault_ff, fault_in;

   logic [lsft_pkg::TimerW-1:0]       report_adv;
   logic [lsft_pkg::TimerW-1:0]       wait_adv;
   logic [lsft_pkg::TimerW-1:0]       fault_adv;
   logic                              timed_out;
   logic                              pending_tick;
   lsft_pkg::cond_type                cond_tick;
   logic                              hold_hit;
   logic                              fire;

   // feedback tick datapath
   always_comb begin
      report_adv   = lsft_pkg::sat_add(report_ff, cfg.sample_period);
      wait_adv     = pending_ff ? lsft_pkg::sat_add(wait_ff, cfg.sample_period)
                                : '0;
      timed_out    = pending_ff &&
                     (wait_adv >= {{(lsft_pkg::TimerW-lsft_pkg::CfgWidth){1'b0}},
                                   cfg.reply_timeout});
      pending_tick = pending_ff && !timed_out;
      cond_tick    = cond_ff;
      if ((item.sample > cfg.feedback_threshold && cond_ff == lsft_pkg::COND_OFF) ||
          (item.sample < cfg.feedback_threshold && cond_ff == lsft_pkg::COND_ON))
         cond_tick = lsft_pkg::COND_FAULT;
      fault_adv    = (cond_tick == lsft_pkg::COND_FAULT)
                     ? lsft_pkg::sat_add(fault_ff, cfg.sample_period) : '0;
      hold_hit     = fault_adv >= {{(lsft_pkg::TimerW-lsft_pkg::CfgWidth){1'b0}},
                                   cfg.fault_hold};
      fire         = armed_ff &&
                     ((report_adv >= {{(lsft_pkg::TimerW-lsft_pkg::CfgWidth){1'b0}},
                                      cfg.report_period}) || hold_hit);
   end

   always_comb begin
      relay_in   = relay_ff;
      cond_in    = cond_ff;
      follow_in  = follow_ff;
      armed_in   = armed_ff;
      pending_in = pending_ff;
      report_in  = report_ff;
      wait_in    = wait_ff;
      fault_in   = fault_ff;
      result.start_report    = 1'b0;
      result.reply_timed_out = 1'b0;
      case (item.action)
         lsft_pkg::ACT_LIGHT: begin
            if (follow_ff) begin
               relay_in = !(item.sample > cfg.light_threshold);
               cond_in  = relay_in ? lsft_pkg::COND_ON : lsft_pkg::COND_OFF;
            end
         end
         lsft_pkg::ACT_FEEDBACK: begin
            wait_in    = wait_adv;
            cond_in    = cond_tick;
            result.reply_timed_out = timed_out;
            result.start_report    = fire;
            armed_in   = armed_ff && !fire;
            pending_in = pending_tick || fire;
            report_in  = fire ? '0 : report_adv;
            fault_in   = (fire && hold_hit) ? '0 : fault_adv;
         end
         lsft_pkg::ACT_MODE: begin
            follow_in = (item.command == lsft_pkg::CMD_AUTO);
            if (item.command == lsft_pkg::CMD_MANUAL_OFF) begin
               relay_in = 1'b0;
               cond_in  = lsft_pkg::COND_OFF;
            end else if (item.command == lsft_pkg::CMD_MANUAL_ON) begin
               relay_in = 1'b1;
               cond_in  = lsft_pkg::COND_ON;
            end
         end
         lsft_pkg::ACT_LINK: begin
            case (item.link_event)
               lsft_pkg::LINK_ARM:  armed_in = 1'b1;
               lsft_pkg::LINK_LOST: armed_in = 1'b0;
               lsft_pkg::LINK_DONE: begin
                  armed_in   = 1'b1;
                  pending_in = 1'b0;
               end
               lsft_pkg::LINK_STARTED: pending_in = 1'b1;
               default: pending_in = pending_ff;
            endcase
         end
         default: relay_in = relay_ff;
      endcase
      result.lamp_on    = relay_in;
      result.lamp_state = cond_in;
      result.auto_mode  = follow_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         relay_ff   <= 1'b0;
         cond_ff    <= lsft_pkg::COND_OFF;
         follow_ff  <= 1'b1;
         armed_ff   <= 1'b0;
         pending_ff <= 1'b0;
         report_ff  <= '0;
         wait_ff    <= '0;
         fault_ff   <= '0;
      end else if (advance) begin
         relay_ff   <= relay_in;
         cond_ff    <= cond_in;
         follow_ff  <= follow_in;
         armed_ff   <= armed_in;
         pending_ff <= pending_in;
         report_ff  <= report_in;
         wait_ff    <= wait_in;
         fault_ff   <= fault_in;
      end
   end

endmodule

@@ hw/rtl/lamp_supervisor_with_fault_timer_top.sv @@
// Lamp supervisor with fault timer.
// req_* channel: one item per transfer (light sample, feedback tick, mode
// command or link event). rsp_* channel: one result per item, in order,
// carrying relay drive, lamp condition, mode and the report/timeout pulses.
// csr_* port: plain register write, taken at any edge with csr_wr_en high;
// write only while no item is in flight. Indexes 6 and 7 are ignored.
// An accepted item passes through the input register, then the supervisor
// state update into the result register, before it is presented on rsp_*.
// Throughput: one item per cycle while the receiver takes results; the state
// update is a single 32-bit saturating add and compare per timer between the
// two registers. Reset empties both pipeline registers, puts the lamp off in
// auto mode with reports disarmed and all timers at zero, and loads the
// default thresholds and periods.
// When the receiver stalls, the result register holds its item and the
// input register can still take one more; req_ready drops only when both
// are occupied, and recovers in the cycle rsp_ready returns.
module lamp_supervisor_with_fault_timer_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_action,
   input  logic [lsft_pkg::SampleW-1:0]      req_sample,
   input  logic [1:0]                        req_command,
   input  logic [1:0]                        req_link_event,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_lamp_on,
   output logic [1:0]                        rsp_lamp_state,
   output logic                              rsp_auto_mode,
   output logic                              rsp_start_report,
   output logic                              rsp_reply_timed_out,
   input  logic                              csr_wr_en,
   input  logic [lsft_pkg::CfgIdxW-1:0]      csr_index,
   input  logic [lsft_pkg::CfgWidth-1:0]     csr_wdata
);

   lsft_pkg::cfg_type    cfg;
   lsft_pkg::item_type   item_ff;
   logic                 item_valid_ff;
   lsft_pkg::result_type result;
   lsft_pkg::result_type rsp_ff;
   logic                 rsp_valid_ff;
   logic                 advance;
   logic                 req_xfer;

   assign advance   = item_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !item_valid_ff || advance;
   assign req_xfer  = req_valid && req_ready;

   lsft_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   lsft_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item_ff),
      .cfg     (cfg),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= req_xfer || (item_valid_ff && !advance);
         rsp_valid_ff  <= advance || (rsp_valid_ff && !rsp_ready);
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         item_ff.action     <= lsft_pkg::action_type'(req_action);
         item_ff.sample     <= req_sample;
         item_ff.command    <= lsft_pkg::command_type'(req_command);
         item_ff.link_event <= lsft_pkg::link_type'(req_link_event);
      end
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_lamp_on         = rsp_ff.lamp_on;
   assign rsp_lamp_state      = rsp_ff.lamp_state;
   assign rsp_auto_mode       = rsp_ff.auto_mode;
   assign rsp_start_report    = rsp_ff.start_report;
   assign rsp_reply_timed_out = rsp_ff.reply_timed_out;

endmodule

@@ test/testbench.sv @@
module testbench;
   import lsft_pkg::*;

   localparam logic [CfgIdxW-1:0] REG_SPARE_6 = 3'd6;
   localparam logic [CfgIdxW-1:0] REG_SPARE_7 = 3'd7;
   localparam int unsigned BATCH_ITEMS = 280;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic req_valid = 1'b0;
   logic req_ready;
   item_type req_item = '0;

   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_lamp_on;
   logic [1:0] rsp_lamp_state;
   logic rsp_auto_mode;
   logic rsp_start_report;
   logic rsp_reply_timed_out;

   logic csr_wr_en = 1'b0;
   logic [CfgIdxW-1:0] csr_index = '0;
   logic [CfgWidth-1:0] csr_wdata = '0;

   // supervisor state as the testbench expects it
   cfg_type cfg;
   logic relay_on;
   cond_type lamp_cond;
   logic follow_light;
   logic reports_armed;
   logic reply_wait;
   logic [TimerW-1:0] report_ms;
   logic [TimerW-1:0] wait_ms;
   logic [TimerW-1:0] fault_ms;

   item_type items_to_send[$];
   result_type status_due[$];
   bit req_taken = 1'b0;
   int idle_pct = 0;
   int stall_pct = 0;
   int failures = 0;

   lamp_supervisor_with_fault_timer_top DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_action(req_item.action),
      .req_sample(req_item.sample),
      .req_command(req_item.command),
      .req_link_event(req_item.link_event),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_lamp_on(rsp_lamp_on),
      .rsp_lamp_state(rsp_lamp_state),
      .rsp_auto_mode(rsp_auto_mode),
      .rsp_start_report(rsp_start_report),
      .rsp_reply_timed_out(rsp_reply_timed_out),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("FAILURE");
      $finish;
   end

   function automatic logic [TimerW-1:0] timer_add(input logic [TimerW-1:0] acc,
                                                   input logic [CfgWidth-1:0] step);
      if (acc > {TimerW{1'b1}} - step) return {TimerW{1'b1}};
      return acc + step;
   endfunction

   function automatic void set_lamp(input logic on);
      relay_on = on;
      lamp_cond = on ? COND_ON : COND_OFF;
   endfunction

   function automatic result_type supervise(input item_type it);
      result_type r;
      r = '0;
      case (it.action)
         ACT_LIGHT: begin
            if (follow_light) set_lamp(!(it.sample > cfg.light_threshold));
         end
         ACT_FEEDBACK: begin
            report_ms = timer_add(report_ms, cfg.sample_period);
            wait_ms = reply_wait ? timer_add(wait_ms, cfg.sample_period) : '0;
            if (reply_wait && wait_ms >= cfg.reply_timeout) begin
               reply_wait = 1'b0;
               r.reply_timed_out = 1'b1;
            end
            if ((it.sample > cfg.feedback_threshold && lamp_cond == COND_OFF) ||
                (it.sample < cfg.feedback_threshold && lamp_cond == COND_ON))
               lamp_cond = COND_FAULT;
            fault_ms = (lamp_cond == COND_FAULT) ? timer_add(fault_ms, cfg.sample_period) : '0;
            if (reports_armed &&
                (report_ms >= cfg.report_period || fault_ms >= cfg.fault_hold)) begin
               r.start_report = 1'b1;
               reports_armed = 1'b0;
               reply_wait = 1'b1;
               report_ms = '0;
               if (fault_ms >= cfg.fault_hold) fault_ms = '0;
            end
         end
         ACT_MODE: begin
            follow_light = (it.command == CMD_AUTO);
            if (it.command == CMD_MANUAL_OFF) set_lamp(1'b0);
            else if (it.command == CMD_MANUAL_ON) set_lamp(1'b1);
         end
         default: begin
            case (it.link_event)
               LINK_ARM: reports_armed = 1'b1;
               LINK_LOST: reports_armed = 1'b0;
               LINK_DONE: begin
                  reply_wait = 1'b0;
                  reports_armed = 1'b1;
               end
               default: reply_wait = 1'b1;
            endcase
         end
      endcase
      r.lamp_on = relay_on;
      r.lamp_state = lamp_cond;
      r.auto_mode = follow_light;
      return r;
   endfunction

   // driver: offers the next queued item, holds it until the transfer
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
         if (!req_valid || req_taken) begin
            if (items_to_send.size() != 0 && $urandom_range(99) >= idle_pct) begin
               req_item <= items_to_send.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: checks result transfers, predicts on request transfers
   always @(posedge clock) begin : monitor
      result_type want;
      result_type got;
      if (reset) begin
         req_taken = 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got.lamp_on = rsp_lamp_on;
            got.lamp_state = cond_type'(rsp_lamp_state);
            got.auto_mode = rsp_auto_mode;
            got.start_report = rsp_start_report;
            got.reply_timed_out = rsp_reply_timed_out;
            if (status_due.size() == 0) begin
               $error("result transfer with no status expected");
               failures++;
            end else begin
               want = status_due.pop_front();
               if (got.lamp_on !== want.lamp_on) begin
                  $error("lamp_on: expected %0d, got %0d", want.lamp_on, got.lamp_on);
                  failures++;
               end
               if (got.lamp_state !== want.lamp_state) begin
                  $error("lamp_state: expected %0d, got %0d", want.lamp_state,
                         got.lamp_state);
                  failures++;
               end
               if (got.auto_mode !== want.auto_mode) begin
                  $error("auto_mode: expected %0d, got %0d", want.auto_mode, got.auto_mode);
                  failures++;
               end
               if (got.start_report !== want.start_report) begin
                  $error("start_report: expected %0d, got %0d", want.start_report,
                         got.start_report);
                  failures++;
               end
               if (got.reply_timed_out !== want.reply_timed_out) begin
                  $error("reply_timed_out: expected %0d, got %0d", want.reply_timed_out,
                         got.reply_timed_out);
                  failures++;
               end
            end
         end
         req_taken = req_valid && req_ready;
         if (req_taken) status_due.push_back(supervise(req_item));
      end
   end

   task automatic queue_item(input action_type act, input logic [SampleW-1:0] level,
                             input command_type cmd, input link_type link);
      item_type it;
      it.action = act;
      it.sample = level;
      it.command = cmd;
      it.link_event = link;
      items_to_send.push_back(it);
   endtask

   function automatic logic [SampleW-1:0] pick_level(input logic [SampleW-1:0] thr);
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         2: return thr - 1'b1;
         3: return thr;
         4: return thr + 1'b1;
         default: return SampleW'($urandom_range(65535));
      endcase
   endfunction

   function automatic item_type random_item();
      item_type it;
      int roll;
      roll = $urandom_range(99);
      it.command = command_type'($urandom_range(3));
      it.link_event = link_type'($urandom_range(3));
      it.sample = SampleW'($urandom_range(65535));
      if (roll < 15) begin
         it.action = ACT_LIGHT;
         it.sample = pick_level(cfg.light_threshold);
      end else if (roll < 62) begin
         it.action = ACT_FEEDBACK;
         it.sample = pick_level(cfg.feedback_threshold);
      end else if (roll < 75) begin
         it.action = ACT_MODE;
      end else begin
         it.action = ACT_LINK;
         // lean toward arming so reports and timeouts keep happening
         roll = $urandom_range(99);
         it.link_event = roll < 35 ? LINK_ARM : roll < 60 ? LINK_DONE :
                         roll < 80 ? LINK_STARTED : LINK_LOST;
      end
      return it;
   endfunction

   task automatic drain();
      while (items_to_send.size() != 0 || req_valid || status_due.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgWidth-1:0] val);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         REG_LIGHT_THRESHOLD: cfg.light_threshold = val;
         REG_FEEDBACK_THRESHOLD: cfg.feedback_threshold = val;
         REG_REPORT_PERIOD: cfg.report_period = val;
         REG_SAMPLE_PERIOD: cfg.sample_period = val;
         REG_FAULT_HOLD: cfg.fault_hold = val;
         REG_REPLY_TIMEOUT: cfg.reply_timeout = val;
         default: ;
      endcase
   endtask

   task automatic write_all(input logic [CfgWidth-1:0] val);
      write_reg(REG_LIGHT_THRESHOLD, val);
      write_reg(REG_FEEDBACK_THRESHOLD, val);
      write_reg(REG_REPORT_PERIOD, val);
      write_reg(REG_SAMPLE_PERIOD, val);
      write_reg(REG_FAULT_HOLD, val);
      write_reg(REG_REPLY_TIMEOUT, val);
   endtask

   // half a batch, wait for every status, then the other half
   task automatic run_batch();
      repeat (BATCH_ITEMS / 2) items_to_send.push_back(random_item());
      drain();
      repeat (BATCH_ITEMS / 2) items_to_send.push_back(random_item());
      drain();
   endtask

   initial begin
      int unsigned step;
      cfg.light_threshold = LightThresholdRst;
      cfg.feedback_threshold = FeedbackThresholdRst;
      cfg.report_period = ReportPeriodRst;
      cfg.sample_period = SamplePeriodRst;
      cfg.fault_hold = FaultHoldRst;
      cfg.reply_timeout = ReplyTimeoutRst;
      relay_on = 1'b0;
      lamp_cond = COND_OFF;
      follow_light = 1'b1;
      reports_armed = 1'b0;
      reply_wait = 1'b0;
      report_ms = '0;
      wait_ms = '0;
      fault_ms = '0;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed pass at reset settings
      queue_item(ACT_LIGHT, 16'hFFFF, CMD_MANUAL_KEEP, LINK_STARTED);
      queue_item(ACT_LIGHT, LightThresholdRst, CMD_MANUAL_OFF, LINK_ARM);
      queue_item(ACT_LIGHT, LightThresholdRst + 1'b1, CMD_MANUAL_ON, LINK_LOST);
      queue_item(ACT_LIGHT, 16'h0000, CMD_AUTO, LINK_DONE);
      queue_item(ACT_FEEDBACK, FeedbackThresholdRst, CMD_AUTO, LINK_ARM);
      queue_item(ACT_FEEDBACK, FeedbackThresholdRst - 1'b1, CMD_AUTO, LINK_ARM);
      queue_item(ACT_MODE, 16'h5555, CMD_MANUAL_OFF, LINK_ARM);
      queue_item(ACT_LIGHT, 16'h0000, CMD_AUTO, LINK_ARM);
      queue_item(ACT_FEEDBACK, 16'hFFFF, CMD_AUTO, LINK_ARM);
      queue_item(ACT_MODE, 16'hAAAA, CMD_MANUAL_KEEP, LINK_ARM);
      queue_item(ACT_MODE, 16'h0000, CMD_MANUAL_ON, LINK_ARM);
      queue_item(ACT_MODE, 16'h0000, CMD_AUTO, LINK_ARM);
      queue_item(ACT_LINK, 16'h0000, CMD_AUTO, LINK_ARM);
      // fault time builds to the hold and a report fires
      repeat (10) queue_item(ACT_FEEDBACK, 16'h0000, CMD_AUTO, LINK_ARM);
      queue_item(ACT_LINK, 16'h0000, CMD_AUTO, LINK_STARTED);
      queue_item(ACT_LINK, 16'h0000, CMD_AUTO, LINK_LOST);
      queue_item(ACT_LINK, 16'h0000, CMD_AUTO, LINK_DONE);
      drain();
      run_batch();

      // everything at zero; spare indexes must not disturb anything
      write_all(16'h0000);
      write_reg(REG_SPARE_6, 16'hFFFF);
      write_reg(REG_SPARE_7, 16'hFFFF);
      idle_pct = 49;
      run_batch();
      run_batch();

      write_all(16'hFFFF);
      idle_pct = 0;
      stall_pct = 49;
      run_batch();
      run_batch();

      idle_pct = 34;
      stall_pct = 34;
      repeat (2) begin
         step = $urandom_range(1, 2000);
         write_reg(REG_SAMPLE_PERIOD, CfgWidth'(step));
         write_reg(REG_REPORT_PERIOD, CfgWidth'($urandom_range(0, 8 * step)));
         write_reg(REG_FAULT_HOLD, CfgWidth'($urandom_range(0, 8 * step)));
         write_reg(REG_REPLY_TIMEOUT, CfgWidth'($urandom_range(0, 4 * step)));
         write_reg(REG_LIGHT_THRESHOLD, CfgWidth'($urandom_range(65535)));
         write_reg(REG_FEEDBACK_THRESHOLD, CfgWidth'($urandom_range(65535)));
         run_batch();
      end

      repeat (6) @(posedge clock);
      if (failures == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
